[design/tsrf_pkg.sv]
// ----------------------------------------------------------------------------
// tsrf_pkg
// Shared types and constants for the tire slip relaxation filter.
// ----------------------------------------------------------------------------
package tsrf_pkg;

    // Field widths.
    localparam int SLIP_W  = 19;
    localparam int SPEED_W = 17;
    localparam int DT_W    = 20;
    localparam int LEN_W   = 15;
    localparam int MINV_W  = 13;

    // Stream word widths, padded to whole bytes.
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 40;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_LEN = 2'd0,
        CFG_LAT_LEN  = 2'd1,
        CFG_MIN_SPD  = 2'd2
    } cfg_index_t;

    // Register reset values and legal ranges.
    localparam logic [LEN_W-1:0]  LEN_RESET  = 15'd512;
    localparam logic [MINV_W-1:0] MINV_RESET = 13'd256;
    localparam logic [LEN_W-1:0]  LEN_MIN    = 15'd10;
    localparam logic [LEN_W-1:0]  LEN_MAX    = 15'd20480;
    localparam logic [MINV_W-1:0] SPEED_MAX  = 13'd5120;

    // Exponent cap (16.0 in Q16) and unity in Q30.
    localparam logic [31:0] X_CAP   = 32'd1048576;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;

    // Default number of compounding steps in the exp approximation.
    localparam int EXP_DEPTH_DEF = 256;

    // Shared multiplier operand width.
    localparam int MUL_W = 32;

    // Shared divider widths.
    localparam int DIV_NUM_W = 37;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_Q_W   = 32;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
    } div_rsp_t;

endpackage

[design/tsrf_mul.sv]
// ----------------------------------------------------------------------------
// tsrf_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module tsrf_mul import tsrf_pkg::*; (
    input  logic               aclk,
    input  logic [MUL_W-1:0]   a,
    input  logic [MUL_W-1:0]   b,
    output logic [2*MUL_W-1:0] p
);

    logic [2*MUL_W-1:0] p_reg;

    // The product is registered and is ready in the cycle after the operands are presented.
    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

[design/tsrf_div.sv]
// ----------------------------------------------------------------------------
// tsrf_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsrf_div import tsrf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_cmd_t cmd,
    output div_rsp_t rsp
);

    localparam int CNT_W   = $clog2(DIV_Q_W + 1);
    localparam int SHIFT_W = DIV_DEN_W + DIV_Q_W - 1;

    logic [DIV_NUM_W-1:0] rem_reg;
    logic [SHIFT_W-1:0]   den_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [SHIFT_W-1:0]   rem_ext;
    logic [SHIFT_W-1:0]   rem_sub;
    logic                 fits;

    // Trial subtraction of the shifted divisor.
    always_comb begin
        rem_ext = SHIFT_W'(rem_reg);
        rem_sub = rem_ext - den_reg;
        fits    = (rem_ext >= den_reg);
    end

    // The quotient is assumed to fit in DIV_Q_W bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                rem_reg  <= cmd.dividend;
                den_reg  <= {cmd.divisor, {(DIV_Q_W-1){1'b0}}};
                q_reg    <= '0;
                cnt_reg  <= CNT_W'(DIV_Q_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (fits) begin
                    rem_reg <= rem_sub[DIV_NUM_W-1:0];
                end
                q_reg   <= {q_reg[DIV_Q_W-2:0], fits};
                den_reg <= den_reg >> 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

[design/tire_slip_relaxation_filter_unit.sv]
// ----------------------------------------------------------------------------
// tire_slip_relaxation_filter_unit
// Two-channel speed-dependent first-order lag for tire slip and slip angle.
// ----------------------------------------------------------------------------
// Each input word carries the target slip, target slip angle, transport
// speed and time step of one physics tick. The block moves its two held
// states toward the targets by blend = 1 - exp(-v*dt/L) and returns one
// output word with both updated states.
// Configuration is written over the cfg channel (index 0: longitudinal
// length, 1: lateral length, 2: minimum speed); the user is to write it
// only while the block is idle, as the block itself does not enforce this.
// cfg_ready is always high and writes to other indexes are dropped. Per
// channel the work is the serial division for the exponent, one quotient
// bit a cycle, and then the square-and-multiply sweep over the bits of
// EXP_TABLE_DEPTH on the shared multiplier; the two channels run in turn.
// A bad configuration skips this work and the held states go unchanged
// to the output register.
// s_tready is high only while no word is in work. A finished word waits in
// the output register if m_tready is low; the next input word is still
// taken, and its result waits until the output register is free.
// Reset restores the register defaults and clears both states to zero.
// ----------------------------------------------------------------------------
module tire_slip_relaxation_filter_unit import tsrf_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Fields from bit 0: target_long_slip[18:0], target_slip_angle[37:19],
    // speed[54:38], time_step[74:55], zero padding[79:75].
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: long_slip[18:0], slip_angle[37:19],
    // zero padding[39:38].
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NBITS = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int BIT_W = $clog2(NBITS);
    localparam logic [NBITS-1:0] DEPTH_VEC = NBITS'(EXP_TABLE_DEPTH);

    // Reciprocal of the depth, 2^34 / EXP_TABLE_DEPTH, for the exp step.
    localparam longint unsigned  RECIP_FULL = (64'd1 << 34) / 64'(EXP_TABLE_DEPTH);
    localparam logic [MUL_W-1:0] STEP_RECIP = MUL_W'(RECIP_FULL);
    localparam logic [MUL_W-1:0] DEPTH_MUL  = MUL_W'(EXP_TABLE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_STEP_MUL,
        ST_STEP_EST,
        ST_STEP_FIX,
        ST_PW_ACC,
        ST_PW_SQR,
        ST_PW_NEXT,
        ST_BLEND,
        ST_MOVE,
        ST_WB
    } state_t;

    state_t state_reg;

    // Configuration and filter state.
    logic [LEN_W-1:0]  long_len_reg;
    logic [LEN_W-1:0]  lat_len_reg;
    logic [MINV_W-1:0] min_speed_reg;
    logic [SLIP_W-1:0] long_state_reg;
    logic [SLIP_W-1:0] angle_state_reg;

    // Working registers for the word in flight.
    logic [SLIP_W-1:0]   tgt_long_reg;
    logic [SLIP_W-1:0]   tgt_angle_reg;
    logic [SPEED_W-1:0]  v_reg;
    logic [DT_W-1:0]     dt_reg;
    logic                ch_reg;
    logic [20:0]         x_reg;
    logic [30:0]         step_reg;
    logic [30:0]         base_reg;
    logic [30:0]         acc_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic                neg_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tvalid_reg;

    // Shared units.
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] mul_p;
    div_cmd_t           div_cmd;
    div_rsp_t           div_rsp;

    tsrf_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    tsrf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .rsp     (div_rsp)
    );

    // Input decode and speed magnitude, floored at the minimum speed.
    logic               s_accept;
    logic               wb_load;
    logic               cfg_ok;
    logic [SPEED_W-1:0] sp_in;
    logic [SPEED_W:0]   sp_ext;
    logic [SPEED_W:0]   sp_abs;
    logic [SPEED_W-1:0] v_in;

    always_comb begin
        s_accept = s_tvalid && (state_reg == ST_IDLE);
        wb_load  = (state_reg == ST_WB) && (!m_tvalid_reg || m_tready);
        cfg_ok   = (long_len_reg >= LEN_MIN) && (long_len_reg <= LEN_MAX)
                && (lat_len_reg >= LEN_MIN) && (lat_len_reg <= LEN_MAX)
                && (min_speed_reg <= SPEED_MAX);
        sp_in    = s_tdata[54:38];
        sp_ext   = {sp_in[SPEED_W-1], sp_in};
        sp_abs   = sp_ext[SPEED_W] ? -sp_ext : sp_ext;
        v_in     = sp_abs[SPEED_W-1:0];
        if (v_in < SPEED_W'(min_speed_reg)) begin
            v_in = SPEED_W'(min_speed_reg);
        end
    end

    // Channel selection, rounding of products and the blend factor.
    logic [LEN_W-1:0]  cur_len;
    logic [SLIP_W-1:0] cur_state;
    logic [SLIP_W-1:0] cur_target;
    logic [SLIP_W:0]   diff;
    logic [SLIP_W:0]   mag;
    logic [61:0]       q30_sum;
    logic [30:0]       q30_rnd;
    logic [31:0]       e_sum;
    logic [16:0]       e_val;
    logic [16:0]       blend;
    logic [36:0]       d_sum;
    logic [SLIP_W:0]   d_val;
    logic [SLIP_W:0]   delta;
    logic [SLIP_W:0]   new_state;
    logic [30:0]       q_est;
    logic [42:0]       step_rem;
    logic [30:0]       step_fix;
    logic [30:0]       base_new;

    always_comb begin
        cur_len    = ch_reg ? lat_len_reg : long_len_reg;
        cur_state  = ch_reg ? angle_state_reg : long_state_reg;
        cur_target = ch_reg ? tgt_angle_reg : tgt_long_reg;
        diff       = {cur_target[SLIP_W-1], cur_target}
                   - {cur_state[SLIP_W-1], cur_state};
        mag        = diff[SLIP_W] ? -diff : diff;

        q30_sum    = mul_p[61:0] + 62'd536870912;
        q30_rnd    = q30_sum[60:30];

        e_sum      = {1'b0, acc_reg} + 32'd8192;
        e_val      = e_sum[30:14];
        if (e_val > 17'd65536) begin
            e_val = 17'd65536;
        end
        blend      = 17'd65536 - e_val;

        d_sum      = mul_p[36:0] + 37'd32768;
        d_val      = d_sum[35:16];
        delta      = neg_reg ? -d_val : d_val;
        new_state  = {cur_state[SLIP_W-1], cur_state} + delta;

        // Step x*2^14/depth: the reciprocal estimate is exact or one low,
        // and one compare of the remainder against the depth settles it.
        q_est      = mul_p[50:20];
        step_rem   = 43'({x_reg, 14'd0}) - mul_p[42:0];
        if (step_rem >= 43'(EXP_TABLE_DEPTH)) begin
            step_fix = step_reg + 31'd1;
        end else begin
            step_fix = step_reg;
        end

        if (step_fix >= ONE_Q30) begin
            base_new = '0;
        end else begin
            base_new = ONE_Q30 - step_fix;
        end
    end

    // Operand steering for the shared multiplier and divider.
    always_comb begin
        mul_a            = '0;
        mul_b            = '0;
        div_cmd.start    = 1'b0;
        div_cmd.dividend = '0;
        div_cmd.divisor  = '0;
        unique case (state_reg)
            ST_PROD: begin
                mul_a = MUL_W'(v_reg);
                mul_b = MUL_W'(dt_reg);
            end
            ST_DIVX_GO: begin
                div_cmd.start    = 1'b1;
                div_cmd.dividend = mul_p[DIV_NUM_W-1:0];
                div_cmd.divisor  = {cur_len, 2'b00};
            end
            ST_STEP_MUL: begin
                mul_a = MUL_W'(x_reg);
                mul_b = STEP_RECIP;
            end
            ST_STEP_EST: begin
                mul_a = MUL_W'(q_est);
                mul_b = DEPTH_MUL;
            end
            ST_PW_ACC: begin
                mul_a = MUL_W'(acc_reg);
                mul_b = MUL_W'(base_reg);
            end
            ST_PW_SQR: begin
                mul_a = MUL_W'(base_reg);
                mul_b = MUL_W'(base_reg);
            end
            ST_BLEND: begin
                mul_a = MUL_W'(mag);
                mul_b = MUL_W'(blend);
            end
            default: begin
            end
        endcase
    end

    // Sequencer, configuration registers, states and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            long_len_reg    <= LEN_RESET;
            lat_len_reg     <= LEN_RESET;
            min_speed_reg   <= MINV_RESET;
            long_state_reg  <= '0;
            angle_state_reg <= '0;
            ch_reg          <= 1'b0;
            bit_reg         <= '0;
        end else begin
            // Configuration writes.
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_LONG_LEN: long_len_reg  <= cfg_data[LEN_W-1:0];
                    CFG_LAT_LEN:  lat_len_reg   <= cfg_data[LEN_W-1:0];
                    CFG_MIN_SPD:  min_speed_reg <= cfg_data[MINV_W-1:0];
                    default: begin
                    end
                endcase
            end

            // The output word is loaded when the register is free and
            // leaves on its handshake.
            if (wb_load) begin
                m_tdata_reg  <= {2'b00, angle_state_reg, long_state_reg};
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        tgt_long_reg  <= s_tdata[18:0];
                        tgt_angle_reg <= s_tdata[37:19];
                        v_reg         <= v_in;
                        dt_reg        <= s_tdata[74:55];
                        ch_reg        <= 1'b0;
                        state_reg     <= cfg_ok ? ST_PROD : ST_WB;
                    end
                end
                ST_PROD: begin
                    state_reg <= ST_DIVX_GO;
                end
                ST_DIVX_GO: begin
                    state_reg <= ST_DIVX_WAIT;
                end
                ST_DIVX_WAIT: begin
                    // Exponent in Q16, saturated at 16.0.
                    if (div_rsp.done) begin
                        if (div_rsp.quotient > X_CAP) begin
                            x_reg <= X_CAP[20:0];
                        end else begin
                            x_reg <= div_rsp.quotient[20:0];
                        end
                        state_reg <= ST_STEP_MUL;
                    end
                end
                ST_STEP_MUL: begin
                    state_reg <= ST_STEP_EST;
                end
                ST_STEP_EST: begin
                    step_reg  <= q_est;
                    state_reg <= ST_STEP_FIX;
                end
                ST_STEP_FIX: begin
                    base_reg  <= base_new;
                    acc_reg   <= ONE_Q30;
                    bit_reg   <= '0;
                    state_reg <= ST_PW_ACC;
                end
                ST_PW_ACC: begin
                    state_reg <= ST_PW_SQR;
                end
                ST_PW_SQR: begin
                    // Multiply into the accumulator where the depth bit is set.
                    if (DEPTH_VEC[bit_reg]) begin
                        acc_reg <= q30_rnd;
                    end
                    state_reg <= ST_PW_NEXT;
                end
                ST_PW_NEXT: begin
                    base_reg <= q30_rnd;
                    if (bit_reg == BIT_W'(NBITS - 1)) begin
                        state_reg <= ST_BLEND;
                    end else begin
                        bit_reg   <= bit_reg + BIT_W'(1);
                        state_reg <= ST_PW_ACC;
                    end
                end
                ST_BLEND: begin
                    neg_reg   <= diff[SLIP_W];
                    state_reg <= ST_MOVE;
                end
                ST_MOVE: begin
                    if (ch_reg) begin
                        angle_state_reg <= new_state[SLIP_W-1:0];
                        state_reg       <= ST_WB;
                    end else begin
                        long_state_reg <= new_state[SLIP_W-1:0];
                        ch_reg         <= 1'b1;
                        state_reg      <= ST_PROD;
                    end
                end
                ST_WB: begin
                    if (wb_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tdata   = m_tdata_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign cfg_ready = 1'b1;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tire slip relaxation filter unit.
// ----------------------------------------------------------------------------
// Each input word is a tick with two slip targets, a transport speed and a
// time step. A bit-true model of the two-channel lag runs beside the block,
// and every output word is compared field by field with the oldest entry
// in a FIFO of predicted slip pairs.
// A directed table runs first. It covers the reset state, a zero time step,
// saturation of the exponent, the length and speed limits, illegal register
// values and a write to the unused register index. Random phases follow.
// Each phase writes a new register set and then sends random ticks.
// Both stream sides stall at random, with some phases free of stalls.
// ----------------------------------------------------------------------------
module testbench;
    import tsrf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_PERIOD      = 8;
    localparam int     RESET_CYCLES    = 5;
    localparam int     EXP_DEPTH       = EXP_DEPTH_DEF;
    localparam int     DIR_ROWS        = 25;
    localparam int     RAND_PHASES     = 12;
    localparam int     TICKS_PER_PHASE = 50;
    localparam int     DRAIN_CYCLES    = 250;
    localparam int     MAX_REPORTS     = 10;
    localparam longint LIMIT_CYCLES    = 2_000_000;
    localparam int     PAD_W           = S_DATA_W - 2 * SLIP_W - SPEED_W - DT_W;

    // Register index that no register answers to.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    // Field extremes.
    localparam logic signed [SLIP_W-1:0]  SLIP_MIN = {1'b1, {(SLIP_W-1){1'b0}}};
    localparam logic signed [SLIP_W-1:0]  SLIP_MAX = ~SLIP_MIN;
    localparam logic signed [SPEED_W-1:0] SPD_MIN  = {1'b1, {(SPEED_W-1){1'b0}}};
    localparam logic signed [SPEED_W-1:0] SPD_MAX  = ~SPD_MIN;
    localparam logic [DT_W-1:0]           DT_MAX   = '1;

    localparam longint unsigned Q30_HALF = 64'd1 << 29;

    typedef struct packed {
        logic signed [SLIP_W-1:0]  tgt_long;
        logic signed [SLIP_W-1:0]  tgt_ang;
        logic signed [SPEED_W-1:0] spd;
        logic [DT_W-1:0]           dt;
    } tick_t;

    typedef struct packed {
        logic signed [SLIP_W-1:0] long_slip;
        logic signed [SLIP_W-1:0] slip_angle;
    } slip_pair_t;

    typedef enum logic {ROW_REG, ROW_TICK} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        tick_t                 tick;
        logic                  known;
        slip_pair_t            want;
    } dir_row_t;

    // Clock, reset and block inputs, all known from time zero.
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Model copy of the registers and of the two held slips.
    logic [LEN_W-1:0]         long_len = LEN_RESET;
    logic [LEN_W-1:0]         lat_len  = LEN_RESET;
    logic [MINV_W-1:0]        min_v    = MINV_RESET;
    logic signed [SLIP_W-1:0] long_st  = '0;
    logic signed [SLIP_W-1:0] ang_st   = '0;

    slip_pair_t pending_slips[$];
    dir_row_t   directed [DIR_ROWS];

    bit idle_on     = 1'b1;
    int ready_hold  = 0;
    int error_count = 0;
    int ticks_sent  = 0;
    int words_seen  = 0;
    int reg_writes  = 0;

    tire_slip_relaxation_filter_unit #(
        .EXP_TABLE_DEPTH(EXP_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Blend in Q16 for one channel: 1 - (1 - x/D)^D with x = v*dt/(4*len).
    function automatic logic [16:0] lag_blend(longint unsigned v,
                                              longint unsigned len,
                                              longint unsigned dt);
        longint unsigned x, dec, base, acc, e;
        int n;
        x = (v * dt) / (len * 4);
        if (x > X_CAP) x = X_CAP;
        dec  = (x << 14) / EXP_DEPTH;
        base = (dec >= ONE_Q30) ? 64'd0 : ONE_Q30 - dec;
        acc  = ONE_Q30;
        // Square-and-multiply over the bits of the depth.
        for (n = EXP_DEPTH; n != 0; n = n >> 1) begin
            if (n[0]) acc = (acc * base + Q30_HALF) >> 30;
            base = (base * base + Q30_HALF) >> 30;
        end
        e = (acc + 64'd8192) >> 14;
        if (e > 65536) e = 65536;
        return 17'(65536 - e);
    endfunction

    // Move a held slip toward its target, rounding half away from zero.
    function automatic logic signed [SLIP_W-1:0] slew(logic signed [SLIP_W-1:0] cur,
                                                      logic signed [SLIP_W-1:0] goal,
                                                      logic [16:0] blend);
        longint diff;
        longint unsigned mag, d;
        diff = longint'(goal) - longint'(cur);
        mag  = (diff < 0) ? -diff : diff;
        d    = (mag * blend + 64'd32768) >> 16;
        return SLIP_W'((diff < 0) ? longint'(cur) - longint'(d)
                                  : longint'(cur) + longint'(d));
    endfunction

    // Advance the model by one tick and return the slips it now holds.
    function automatic slip_pair_t filter_tick(tick_t t);
        logic [16:0] bl, ba;
        longint unsigned v;
        if (long_len >= LEN_MIN && long_len <= LEN_MAX &&
            lat_len >= LEN_MIN && lat_len <= LEN_MAX && min_v <= SPEED_MAX) begin
            v = (t.spd < 0) ? -longint'(t.spd) : longint'(t.spd);
            if (v < min_v) v = min_v;
            bl = lag_blend(v, long_len, t.dt);
            ba = lag_blend(v, lat_len, t.dt);
            long_st = slew(long_st, t.tgt_long, bl);
            ang_st  = slew(ang_st, t.tgt_ang, ba);
        end
        return '{long_slip: long_st, slip_angle: ang_st};
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 4);
        if (r < 97) return $urandom_range(5, 24);
        return $urandom_range(50, 300);
    endfunction

    function automatic logic signed [SLIP_W-1:0] rand_slip();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return SLIP_MAX;
        if (r == 1) return SLIP_MIN;
        if (r < 4) return SLIP_W'(int'($urandom_range(0, 4000)) - 2000);
        return SLIP_W'($urandom);
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        int r;
        t.tgt_long = rand_slip();
        t.tgt_ang  = rand_slip();
        r = $urandom_range(0, 9);
        if (r == 0)     t.spd = SPD_MAX;
        else if (r == 1) t.spd = SPD_MIN;
        else if (r < 6) t.spd = SPEED_W'(int'($urandom_range(0, 8192)) - 4096);
        else            t.spd = SPEED_W'($urandom);
        // Time steps spread over all magnitudes so blends cover 0 to 1.
        r = $urandom_range(0, 15);
        if (r == 0)      t.dt = '0;
        else if (r == 1) t.dt = DT_MAX;
        else             t.dt = DT_W'($urandom & ((32'd1 << $urandom_range(1, DT_W)) - 1));
        return t;
    endfunction

    function automatic logic [LEN_W-1:0] pick_len(int ph);
        int r;
        if (ph == 0) return LEN_MIN;
        if (ph == 1) return LEN_MAX;
        r = $urandom_range(0, 19);
        if (r == 0) return LEN_W'($urandom_range(0, LEN_MIN - 1));
        if (r == 1) return LEN_W'($urandom_range(LEN_MAX + 1, (1 << LEN_W) - 1));
        if (r < 4) return r[0] ? LEN_MIN : LEN_MAX;
        if (r < 12) return LEN_W'($urandom_range(LEN_MIN, 2048));
        return LEN_W'($urandom_range(LEN_MIN, LEN_MAX));
    endfunction

    function automatic logic [MINV_W-1:0] pick_minv(int ph);
        int r;
        if (ph == 0) return '0;
        if (ph == 1) return SPEED_MAX;
        r = $urandom_range(0, 19);
        if (r == 0) return MINV_W'($urandom_range(SPEED_MAX + 1, (1 << MINV_W) - 1));
        if (r == 1) return '0;
        if (r == 2) return SPEED_MAX;
        if (r < 10) return MINV_W'($urandom_range(0, 512));
        return MINV_W'($urandom_range(0, SPEED_MAX));
    endfunction

    // Builders for rows of the directed table.
    function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row         = '0;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic dir_row_t tick_row(logic signed [SLIP_W-1:0] tl,
                                          logic signed [SLIP_W-1:0] ta,
                                          logic signed [SPEED_W-1:0] spd,
                                          logic [DT_W-1:0] dt);
        dir_row_t row;
        row      = '0;
        row.kind = ROW_TICK;
        row.tick = '{tgt_long: tl, tgt_ang: ta, spd: spd, dt: dt};
        return row;
    endfunction

    function automatic dir_row_t known_row(logic signed [SLIP_W-1:0] tl,
                                           logic signed [SLIP_W-1:0] ta,
                                           logic signed [SPEED_W-1:0] spd,
                                           logic [DT_W-1:0] dt,
                                           logic signed [SLIP_W-1:0] wl,
                                           logic signed [SLIP_W-1:0] wa);
        dir_row_t row;
        row       = tick_row(tl, ta, spd, dt);
        row.known = 1'b1;
        row.want  = '{long_slip: wl, slip_angle: wa};
        return row;
    endfunction

    task automatic note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
    endtask

    // Write one register once every pending word has come back.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_slips.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_LONG_LEN: long_len = val;
            CFG_LAT_LEN:  lat_len  = val;
            CFG_MIN_SPD:  min_v    = val[MINV_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Send one tick; the expected slips are queued at the accepting edge.
    task automatic send_word(tick_t t, logic known, slip_pair_t want);
        slip_pair_t pred;
        int gap;
        cfg_valid <= 1'b0;
        s_tdata   <= {{PAD_W{1'b0}}, t.dt, t.spd, t.tgt_ang, t.tgt_long};
        s_tvalid  <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pred = filter_tick(t);
        pending_slips.push_back(known ? want : pred);
        ticks_sent++;
        gap = idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Output side: check each accepted word, then pick the next ready level.
    always @(posedge aclk) begin
        slip_pair_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.long_slip  = m_tdata[SLIP_W-1:0];
            got.slip_angle = m_tdata[2*SLIP_W-1:SLIP_W];
            if (pending_slips.size() == 0) begin
                note_error($sformatf("output word with none pending: %0d %0d",
                                     got.long_slip, got.slip_angle));
            end else begin
                want = pending_slips.pop_front();
                words_seen++;
                if (got.long_slip !== want.long_slip)
                    note_error($sformatf("long_slip: expected %0d, got %0d",
                                         want.long_slip, got.long_slip));
                if (got.slip_angle !== want.slip_angle)
                    note_error($sformatf("slip_angle: expected %0d, got %0d",
                                         want.slip_angle, got.slip_angle));
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            m_tready   <= 1'b0;
            ready_hold = pick_gap();
        end else begin
            m_tready   <= 1'b1;
            ready_hold = $urandom_range(0, 12);
        end
    end

    // Stimulus: directed table, then random register sets with random ticks.
    initial begin
        int i, ph, k;
        logic [LEN_W-1:0] lon, lat;
        logic [MINV_W-1:0] mv;

        directed = '{
            // Reset state: zero step keeps both slips at zero.
            known_row(SLIP_MAX, SLIP_MIN, 0, '0, 0, 0),
            // Saturated exponent: the slips land on their targets; a zero step then holds them.
            known_row(SLIP_MAX, SLIP_MIN, SPD_MAX, DT_MAX, SLIP_MAX, SLIP_MIN),
            known_row(SLIP_MIN, SLIP_MAX, SPD_MIN, DT_MAX, SLIP_MIN, SLIP_MAX),
            known_row(0, 0, SPD_MIN, '0, SLIP_MIN, SLIP_MAX),
            tick_row(0, 0, -2560, 1000),
            // Speed below the minimum is raised to it.
            tick_row(65536, -32768, 0, 20000),
            tick_row(1, -1, 1, 1),
            reg_row(CFG_LONG_LEN, LEN_MIN),
            reg_row(CFG_LAT_LEN, LEN_MAX),
            reg_row(CFG_MIN_SPD, '0),
            // Zero transport speed with no minimum gives no movement.
            tick_row(100000, -100000, 0, DT_MAX),
            tick_row(100000, -100000, 3000, 50000),
            reg_row(CFG_MIN_SPD, SPEED_MAX),
            tick_row(-5000, 7000, 0, 4000),
            // Illegal settings freeze both slips.
            reg_row(CFG_LONG_LEN, LEN_MIN - 15'd1),
            tick_row(SLIP_MAX, SLIP_MAX, SPD_MAX, DT_MAX),
            reg_row(CFG_LONG_LEN, LEN_RESET),
            reg_row(CFG_LAT_LEN, LEN_MAX + 15'd1),
            tick_row(SLIP_MIN, SLIP_MIN, -300, 900000),
            reg_row(CFG_LAT_LEN, LEN_RESET),
            reg_row(CFG_MIN_SPD, SPEED_MAX + 13'd1),
            tick_row(12345, -54321, 700, 30000),
            // Bits above the minimum speed field are dropped.
            reg_row(CFG_MIN_SPD, {2'b11, 13'd100}),
            // A write to the unused index changes nothing.
            reg_row(CFG_IDX_SPARE, '0),
            tick_row(-12345, 54321, 50, 60000)
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            if (directed[i].kind == ROW_REG)
                write_reg(directed[i].reg_idx, directed[i].reg_val);
            else
                send_word(directed[i].tick, directed[i].known, directed[i].want);
        end

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            lon = pick_len(ph);
            lat = pick_len(ph);
            mv  = pick_minv(ph);
            write_reg(CFG_LONG_LEN, lon);
            write_reg(CFG_LAT_LEN, lat);
            write_reg(CFG_MIN_SPD, {2'($urandom_range(0, 3)), mv});
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
            idle_on = ($urandom_range(0, 3) != 0);
            for (k = 0; k < TICKS_PER_PHASE; k++)
                send_word(rand_tick(), 1'b0, '0);
        end

        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        idle_on   = 1'b0;
        while (pending_slips.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d ticks with %0d register writes over %0d random settings.",
                 ticks_sent, reg_writes, RAND_PHASES);
        $display("Checked %0d output words, %0d errors.", words_seen, error_count);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
design/tsrf_pkg.sv
design/tsrf_mul.sv
design/tsrf_div.sv
design/tire_slip_relaxation_filter_unit.sv
tb/sv/testbench.sv
